/* sv/tkr_pkg.sv */
package tkr_pkg;

	localparam int FRAME_ROWS = 60;
	localparam int FRAME_COLS = 80;

	localparam int PIX_W = 8;
	localparam int ROW_W = 6;
	localparam int COL_W = 7;
	localparam int DRV_W = 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [1:0] REG_TARGET_COL = 2'd1;
	localparam logic [1:0] REG_TARGET_ROW = 2'd2;

	localparam logic [PIX_W-1:0] THRESHOLD_RESET  = 8'd85;
	localparam logic [COL_W-1:0] TARGET_COL_RESET = 7'd40;
	localparam logic [ROW_W-1:0] TARGET_ROW_RESET = 6'd30;

	// Bounding box of one finished frame, handed from front to back.
	typedef struct packed {
		logic             any_hit;
		logic [COL_W-1:0] min_col;
		logic [COL_W-1:0] max_col;
		logic [ROW_W-1:0] min_row;
		logic [ROW_W-1:0] max_row;
	} box_sum_t;

	// Floor of m/5 for m up to 255, by multiplying with 205/1024.
	function automatic logic [5:0] div5(input logic [7:0] m);
		logic [15:0] p;
		p = {8'd0, m} * 16'd205;
		return p[15:10];
	endfunction

	// Floor of m/3 for m up to 127, by multiplying with 171/512.
	function automatic logic [5:0] div3(input logic [6:0] m);
		logic [15:0] p;
		p = {9'd0, m} * 16'd171;
		return p[14:9];
	endfunction

	// Clamp a 10-bit two's complement value to the 8-bit range.
	function automatic logic [DRV_W-1:0] sat8(input logic [9:0] v);
		logic [DRV_W-1:0] r;
		r = v[7:0];
		if (!v[9] && (v[8:7] != 2'b00)) begin
			r = 8'h7f;
		end else if (v[9] && (v[8:7] != 2'b11)) begin
			r = 8'h80;
		end
		return r;
	endfunction

endpackage

/* sv/tkr_if.sv */
interface tkr_pix_if;
	import tkr_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic             frame_start;

	modport source(output valid, pixel_value, frame_start, input ready);
	modport sink(input valid, pixel_value, frame_start, output ready);
endinterface

interface tkr_res_if;
	import tkr_pkg::*;

	logic             valid;
	logic             ready;
	logic [DRV_W-1:0] servo_x_drive;
	logic [DRV_W-1:0] servo_y_drive;
	logic             target_found;
	logic [COL_W-1:0] centre_col;
	logic [ROW_W-1:0] centre_row;

	modport source(output valid, servo_x_drive, servo_y_drive, target_found, centre_col,
		centre_row, input ready);
	modport sink(input valid, servo_x_drive, servo_y_drive, target_found, centre_col,
		centre_row, output ready);
endinterface

/* sv/tkr_front.sv */
module tkr_front (
	input  logic                     clk,
	input  logic                     arst_n,
	tkr_pix_if.sink                  pixel,
	input  logic [tkr_pkg::PIX_W-1:0] threshold,
	input  logic                     q_ready,
	output logic                     q_push,
	output tkr_pkg::box_sum_t        q_data
);
	import tkr_pkg::*;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] min_row_q;
	logic [ROW_W-1:0] max_row_q;
	logic [COL_W-1:0] min_col_q;
	logic [COL_W-1:0] max_col_q;
	logic             hit_q;

	logic [ROW_W-1:0] row_c;
	logic [COL_W-1:0] col_c;
	logic [ROW_W-1:0] min_row_c;
	logic [ROW_W-1:0] max_row_c;
	logic [COL_W-1:0] min_col_c;
	logic [COL_W-1:0] max_col_c;
	logic             hit_c;

	logic [ROW_W-1:0] min_row_n;
	logic [ROW_W-1:0] max_row_n;
	logic [COL_W-1:0] min_col_n;
	logic [COL_W-1:0] max_col_n;
	logic             hit_n;
	logic             pix_hit;
	logic             last_pix;
	logic             accept;

	assign pixel.ready = q_ready;
	assign accept      = pixel.valid && q_ready;

	always_comb begin
		// A frame start flag clears position and box before this pixel is used.
		if (pixel.frame_start) begin
			row_c     = '0;
			col_c     = '0;
			min_row_c = ROW_W'(FRAME_ROWS);
			max_row_c = '0;
			min_col_c = COL_W'(FRAME_COLS);
			max_col_c = '0;
			hit_c     = 1'b0;
		end else begin
			row_c     = row_q;
			col_c     = col_q;
			min_row_c = min_row_q;
			max_row_c = max_row_q;
			min_col_c = min_col_q;
			max_col_c = max_col_q;
			hit_c     = hit_q;
		end

		pix_hit   = pixel.pixel_value > threshold;
		min_row_n = (pix_hit && (row_c < min_row_c)) ? row_c : min_row_c;
		max_row_n = (pix_hit && (row_c > max_row_c)) ? row_c : max_row_c;
		min_col_n = (pix_hit && (col_c < min_col_c)) ? col_c : min_col_c;
		max_col_n = (pix_hit && (col_c > max_col_c)) ? col_c : max_col_c;
		hit_n     = hit_c || pix_hit;

		last_pix = (row_c == ROW_W'(FRAME_ROWS - 1)) && (col_c == COL_W'(FRAME_COLS - 1));
	end

	assign q_push          = accept && last_pix;
	assign q_data.any_hit  = hit_n;
	assign q_data.min_col  = min_col_n;
	assign q_data.max_col  = max_col_n;
	assign q_data.min_row  = min_row_n;
	assign q_data.max_row  = max_row_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			min_row_q <= ROW_W'(FRAME_ROWS);
			max_row_q <= '0;
			min_col_q <= COL_W'(FRAME_COLS);
			max_col_q <= '0;
			hit_q     <= 1'b0;
		end else if (accept) begin
			if (last_pix) begin
				row_q     <= '0;
				col_q     <= '0;
				min_row_q <= ROW_W'(FRAME_ROWS);
				max_row_q <= '0;
				min_col_q <= COL_W'(FRAME_COLS);
				max_col_q <= '0;
				hit_q     <= 1'b0;
			end else begin
				if (col_c == COL_W'(FRAME_COLS - 1)) begin
					col_q <= '0;
					row_q <= (row_c == ROW_W'(FRAME_ROWS - 1)) ? '0 : row_c + 1'b1;
				end else begin
					col_q <= col_c + 1'b1;
					row_q <= row_c;
				end
				min_row_q <= min_row_n;
				max_row_q <= max_row_n;
				min_col_q <= min_col_n;
				max_col_q <= max_col_n;
				hit_q     <= hit_n;
			end
		end
	end
endmodule

/* sv/tkr_queue.sv */
module tkr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tkr_pkg::box_sum_t push_data,
	output logic              not_full,
	input  logic              pop,
	output logic              head_valid,
	output tkr_pkg::box_sum_t head
);
	import tkr_pkg::*;

	box_sum_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign not_full   = count_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

/* sv/tkr_back.sv */
module tkr_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  tkr_pkg::box_sum_t         head,
	output logic                      pop,
	input  logic [tkr_pkg::COL_W-1:0] target_col,
	input  logic [tkr_pkg::ROW_W-1:0] target_row,
	tkr_res_if.source                 result
);
	import tkr_pkg::*;

	logic             valid_q;
	logic [DRV_W-1:0] drv_x_q;
	logic [DRV_W-1:0] drv_y_q;
	logic             found_q;
	logic [COL_W-1:0] cc_q;
	logic [ROW_W-1:0] cr_q;
	logic [DRV_W-1:0] last_ex_q;
	logic [DRV_W-1:0] last_ey_q;

	logic [COL_W:0]   col_sum;
	logic [ROW_W:0]   row_sum;
	logic [COL_W-1:0] cc;
	logic [ROW_W-1:0] cr;
	logic [8:0]       ex;
	logic [7:0]       ey;
	logic [8:0]       ex_adj;
	logic [8:0]       ex_half;
	logic [9:0]       dx_diff;
	logic [9:0]       dy_diff;
	logic [9:0]       dx_mag;
	logic [9:0]       dy_mag;
	logic [9:0]       qx5;
	logic [9:0]       qy5;
	logic [8:0]       ey2;
	logic [8:0]       ey2_mag;
	logic [9:0]       qy3;
	logic [9:0]       sum_x;
	logic [9:0]       sum_y;

	assign pop = head_valid && (!valid_q || result.ready);

	always_comb begin
		col_sum = {1'b0, head.min_col} + {1'b0, head.max_col};
		row_sum = {1'b0, head.min_row} + {1'b0, head.max_row};
		cc      = col_sum[COL_W:1];
		cr      = row_sum[ROW_W:1];
		ex      = {2'b00, target_col} - {2'b00, cc};
		ey      = {2'b00, target_row} - {2'b00, cr};

		// Halving that rounds toward zero: add one to negative values first.
		ex_adj  = ex + {8'd0, ex[8]};
		ex_half = {ex_adj[8], ex_adj[8:1]};

		// Derivative terms, divided by five in sign-magnitude form.
		dx_diff = {ex[8], ex} - {{2{last_ex_q[7]}}, last_ex_q};
		dy_diff = {{2{ey[7]}}, ey} - {{2{last_ey_q[7]}}, last_ey_q};
		dx_mag  = dx_diff[9] ? (~dx_diff + 10'd1) : dx_diff;
		dy_mag  = dy_diff[9] ? (~dy_diff + 10'd1) : dy_diff;
		qx5     = dx_diff[9] ? (~{4'd0, div5(dx_mag[7:0])} + 10'd1) : {4'd0, div5(dx_mag[7:0])};
		qy5     = dy_diff[9] ? (~{4'd0, div5(dy_mag[7:0])} + 10'd1) : {4'd0, div5(dy_mag[7:0])};

		ey2     = {ey, 1'b0};
		ey2_mag = ey2[8] ? (~ey2 + 9'd1) : ey2;
		qy3     = ey2[8] ? (~{4'd0, div3(ey2_mag[6:0])} + 10'd1) : {4'd0, div3(ey2_mag[6:0])};

		sum_x = {ex_half[8], ex_half} + qx5;
		sum_y = qy3 + qy5;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			found_q <= head.any_hit;
			if (head.any_hit) begin
				drv_x_q <= sat8(sum_x);
				drv_y_q <= sat8(sum_y);
				cc_q    <= cc;
				cr_q    <= cr;
			end else begin
				drv_x_q <= '0;
				drv_y_q <= '0;
				cc_q    <= '0;
				cr_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			last_ex_q <= '0;
			last_ey_q <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
			// An empty frame keeps the previous errors.
			if (pop && head.any_hit) begin
				last_ex_q <= sat8({ex[8], ex});
				last_ey_q <= ey;
			end
		end
	end

	assign result.valid         = valid_q;
	assign result.servo_x_drive = drv_x_q;
	assign result.servo_y_drive = drv_y_q;
	assign result.target_found  = found_q;
	assign result.centre_col    = cc_q;
	assign result.centre_row    = cr_q;
endmodule

/* sv/threshold_box_centroid_pd_tracker.sv */
// Throughput: one pixel word per clock; the input stalls only while the two-entry
// frame queue is full, which needs two finished frames waiting behind a held output.
// The result word of a frame is written into the queue at the clock edge that accepts
// its last pixel; the drive math loads it into the output register when the queue pops
// it, which waits while an unaccepted result is held or older frames are ahead of it.
// Reset (arst_n, asynchronous, active low) clears counters, box, last errors, queue and
// output valid, and loads the registers with threshold 85, target column 40, target row 30.
module threshold_box_centroid_pd_tracker (
	input  logic                       clk,
	input  logic                       arst_n,
	tkr_pix_if.sink                    pixel,
	tkr_res_if.source                  result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tkr_pkg::APB_AW-1:0] paddr,
	input  logic [tkr_pkg::APB_DW-1:0] pwdata,
	output logic [tkr_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import tkr_pkg::*;

	logic [PIX_W-1:0] threshold_q;
	logic [COL_W-1:0] target_col_q;
	logic [ROW_W-1:0] target_row_q;

	logic     q_push;
	logic     q_not_full;
	logic     q_pop;
	logic     q_valid;
	box_sum_t q_in;
	box_sum_t q_head;
	logic     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RESET;
			target_col_q <= TARGET_COL_RESET;
			target_row_q <= TARGET_ROW_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_THRESHOLD:  threshold_q  <= pwdata[PIX_W-1:0];
				REG_TARGET_COL: target_col_q <= pwdata[COL_W-1:0];
				REG_TARGET_ROW: target_row_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_THRESHOLD:  prdata = {{(APB_DW-PIX_W){1'b0}}, threshold_q};
			REG_TARGET_COL: prdata = {{(APB_DW-COL_W){1'b0}}, target_col_q};
			REG_TARGET_ROW: prdata = {{(APB_DW-ROW_W){1'b0}}, target_row_q};
			default:        prdata = '0;
		endcase
	end

	tkr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.threshold (threshold_q),
		.q_ready   (q_not_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	tkr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.not_full   (q_not_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	tkr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.target_col (target_col_q),
		.target_row (target_row_q),
		.result     (result)
	);
endmodule
